// ===== rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, S-box tables and GF(2^8) helpers for the AES-256 core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int ROUNDS    = 14;
  localparam int KEY_WORDS = 8;
  localparam int RK_ROWS   = ROUNDS + 1;
  localparam int RK_WORDS  = 4 * RK_ROWS;

  typedef logic [127:0] block_t;
  typedef logic [3:0]   rk_addr_t;

  localparam logic [7:0] GF_POLY = 8'h1b;
  localparam logic [7:0] RCON_INIT = 8'h01;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

endpackage

// ===== rtl/aes_round.sv =====
// ----------------------------------------------------------------------------
// aes_round
// One AES round, forward or inverse, with an option to skip the column mix
// for the last round. Byte b of the state sits in bits 127-8b down to 120-8b.
// ----------------------------------------------------------------------------
module aes_round (
  input  aes_pkg::block_t state_i,
  input  aes_pkg::block_t round_key,
  input  logic            dec,
  input  logic            last,
  output aes_pkg::block_t state_o
);
  import aes_pkg::*;

  logic [7:0] s   [16];
  logic [7:0] fsb [16];
  logic [7:0] isb [16];
  block_t     fwd_ss;
  block_t     inv_ss;
  block_t     fwd_mix;
  block_t     inv_mix;
  block_t     inv_ak;

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      s[b] = state_i[127 - 8*b -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        fsb[c*4 + r] = FWD_SBOX[s[((c + r) % 4)*4 + r]];
        isb[((c + r) % 4)*4 + r] = INV_SBOX[s[c*4 + r]];
      end
    end
    for (int b = 0; b < 16; b++) begin
      fwd_ss[127 - 8*b -: 8] = fsb[b];
      inv_ss[127 - 8*b -: 8] = isb[b];
    end
  end

  assign inv_ak = inv_ss ^ round_key;

  always_comb begin
    logic [7:0] a  [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] e  [4];
    logic [7:0] i2 [4];
    logic [7:0] i4 [4];
    logic [7:0] i8 [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = fwd_ss[127 - 8*(c*4 + r) -: 8];
        a2[r] = xtime(a[r]);
        e[r]  = inv_ak[127 - 8*(c*4 + r) -: 8];
        i2[r] = xtime(e[r]);
        i4[r] = xtime(i2[r]);
        i8[r] = xtime(i4[r]);
        a4[r] = i4[r];
        a8[r] = i8[r];
      end
      for (int r = 0; r < 4; r++) begin
        // Forward: 2*a0 ^ 3*a1 ^ a2 ^ a3, rotated per row.
        fwd_mix[127 - 8*(c*4 + r) -: 8] = a2[r] ^ a2[(r+1)%4] ^ a[(r+1)%4]
                                          ^ a[(r+2)%4] ^ a[(r+3)%4];
        // Inverse: 14*e0 ^ 11*e1 ^ 13*e2 ^ 9*e3, rotated per row.
        inv_mix[127 - 8*(c*4 + r) -: 8] =
            (a8[r] ^ a4[r] ^ i2[r]) ^
            (i8[(r+1)%4] ^ i2[(r+1)%4] ^ e[(r+1)%4]) ^
            (i8[(r+2)%4] ^ i4[(r+2)%4] ^ e[(r+2)%4]) ^
            (i8[(r+3)%4] ^ e[(r+3)%4]);
      end
    end
  end

  always_comb begin
    priority if (dec) begin
      state_o = last ? inv_ak : inv_mix;
    end else begin
      state_o = (last ? fwd_ss : fwd_mix) ^ round_key;
    end
  end

endmodule

// ===== rtl/aes256_block_cipher.sv =====
// ----------------------------------------------------------------------------
// aes256_block_cipher
// Round-iterative AES-256 encrypt/decrypt core with on-chip key expansion.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Beat content
//  in_      input      in_valid/in_ready  kind, block_high, block_low
//  out_     output     out_valid/out_ready result_high, result_low
//  cfg_     input      cfg_we             key word index, 64-bit data
//
//  A block passes from accept to result through the key-0 addition and the
//  fourteen rounds of the single shared round unit; the first round key is
//  read on the accept edge. After a key write the first block also waits
//  for the schedule to expand, one key word per cycle into the 15-row round-key
//  memory, and for the step that fetches the first round key.
//  Reset is synchronous and active low; the round keys are marked stale and
//  rebuilt before the first block. A stalled result holds the core in its
//  last round until the output register frees.
module aes256_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import aes_pkg::*;

  localparam logic [2:0] CFG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD_3 = 3'd3;
  localparam logic [5:0] KIDX_FIRST = 6'(KEY_WORDS);
  localparam logic [5:0] KIDX_LAST  = 6'(RK_WORDS - 1);
  localparam logic [3:0] LAST_ROUND = 4'(ROUNDS);

  typedef enum logic [2:0] {S_IDLE, S_EXPAND, S_PRIME, S_KEY0, S_ROUND} state_t;

  state_t      state_r;
  logic        stale_r;
  logic        dec_r;
  logic [3:0]  cnt_r;
  logic [5:0]  kidx_r;
  logic [7:0]  rc_r;
  logic [31:0] win_r [KEY_WORDS];
  logic [63:0] key_r [4];
  block_t      blk_r;
  block_t      rk_r;
  block_t      rk_mem [RK_ROWS];
  logic        out_valid_r;
  logic [63:0] out_hi_r;
  logic [63:0] out_lo_r;

  logic        last;
  logic        finish;
  logic        accept;
  logic [31:0] t_word;
  logic [31:0] new_word;
  logic        mem_we;
  rk_addr_t    mem_waddr;
  block_t      mem_wdata;
  rk_addr_t    rd_addr;
  block_t      round_out;

  function automatic rk_addr_t key_of(input logic dec, input logic [3:0] c);
    key_of = dec ? (LAST_ROUND - c) : c;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign last     = (cnt_r == LAST_ROUND);
  assign finish   = (state_r == S_ROUND) && last && (!out_valid_r || out_ready);

  // Next key schedule word from the sliding window of the last eight words.
  always_comb begin
    t_word = win_r[KEY_WORDS-1];
    priority if (kidx_r[2:0] == 3'd0) begin
      t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rc_r, 24'h0};
    end else if (kidx_r[2:0] == 3'd4) begin
      t_word = sub_word(t_word);
    end
    new_word = win_r[0] ^ t_word;
  end

  // Rows 0 and 1 are the key itself and go in at expansion indices 8 and 9,
  // before the first computed row is due.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = kidx_r[5:2];
    mem_wdata = {win_r[5], win_r[6], win_r[7], new_word};
    if (state_r == S_EXPAND) begin
      priority if (kidx_r == KIDX_FIRST) begin
        mem_we    = 1'b1;
        mem_waddr = 4'd0;
        mem_wdata = {key_r[0], key_r[1]};
      end else if (kidx_r == KIDX_FIRST + 6'd1) begin
        mem_we    = 1'b1;
        mem_waddr = 4'd1;
        mem_wdata = {key_r[2], key_r[3]};
      end else if (kidx_r[1:0] == 2'd3) begin
        mem_we    = 1'b1;
      end else begin
        mem_we    = 1'b0;
      end
    end
  end

  always_comb begin
    unique case (state_r)
      S_IDLE:   rd_addr = in_kind ? LAST_ROUND : 4'd0;
      S_EXPAND: rd_addr = 4'd0;
      S_PRIME:  rd_addr = dec_r ? LAST_ROUND : 4'd0;
      S_KEY0:   rd_addr = key_of(dec_r, 4'd1);
      S_ROUND:  rd_addr = last ? key_of(dec_r, cnt_r) : key_of(dec_r, cnt_r + 4'd1);
      default:  rd_addr = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      rk_mem[mem_waddr] <= mem_wdata;
    end
    rk_r <= rk_mem[rd_addr];
  end

  aes_round u_round (
    .state_i   (blk_r),
    .round_key (rk_r),
    .dec       (dec_r),
    .last      (last),
    .state_o   (round_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stale_r     <= 1'b1;
      cnt_r       <= 4'd0;
      kidx_r      <= KIDX_FIRST;
      out_valid_r <= 1'b0;
      for (int k = 0; k < 4; k++) begin
        key_r[k] <= 64'h0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_WORD_0: begin key_r[0] <= cfg_wdata; stale_r <= 1'b1; end
          CFG_KEY_WORD_1: begin key_r[1] <= cfg_wdata; stale_r <= 1'b1; end
          CFG_KEY_WORD_2: begin key_r[2] <= cfg_wdata; stale_r <= 1'b1; end
          CFG_KEY_WORD_3: begin key_r[3] <= cfg_wdata; stale_r <= 1'b1; end
          default: ;
        endcase
      end
      // A new result may replace one that is taken in the same cycle.
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            kidx_r  <= KIDX_FIRST;
            state_r <= stale_r ? S_EXPAND : S_KEY0;
          end
        end
        S_EXPAND: begin
          kidx_r <= kidx_r + 6'd1;
          if (kidx_r == KIDX_LAST) begin
            stale_r <= 1'b0;
            state_r <= S_PRIME;
          end
        end
        S_PRIME: state_r <= S_KEY0;
        S_KEY0: begin
          cnt_r   <= 4'd1;
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          if (!last) begin
            cnt_r <= cnt_r + 4'd1;
          end else if (finish) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      dec_r <= in_kind;
      blk_r <= {in_block_high, in_block_low};
      rc_r  <= RCON_INIT;
      for (int k = 0; k < 4; k++) begin
        win_r[2*k]     <= key_r[k][63:32];
        win_r[2*k + 1] <= key_r[k][31:0];
      end
    end
    if (state_r == S_EXPAND) begin
      for (int k = 0; k < KEY_WORDS - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
      win_r[KEY_WORDS-1] <= new_word;
      if (kidx_r[2:0] == 3'd0) begin
        rc_r <= xtime(rc_r);
      end
    end
    if (state_r == S_KEY0) begin
      blk_r <= blk_r ^ rk_r;
    end
    if (state_r == S_ROUND && !last) begin
      blk_r <= round_out;
    end
    if (finish) begin
      out_hi_r <= round_out[127:64];
      out_lo_r <= round_out[63:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_high = out_hi_r;
  assign out_result_low  = out_lo_r;

endmodule

// ===== rtl/aes_checker.sv =====
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks on the AES-256 core, bound to the top level.
// ----------------------------------------------------------------------------
module aes_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // A result beat stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before acceptance");

  // The core is busy right after taking a block.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second block accepted while busy");

  // No result can appear in the cycle after a block is taken.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

  // A new result is published exactly as the core returns to idle.
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result published while core still busy");

endmodule

bind aes256_block_cipher aes_checker u_aes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

// ===== tb/sv/aes256_block_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// aes256_block_cipher_tb
// Self-checking bench for the AES-256 core: keys are written through the
// register port, random and directed blocks are encrypted and decrypted, and
// every result beat is compared against an in-bench AES-256 model.
// ----------------------------------------------------------------------------
module aes256_block_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aes_pkg::*;

  localparam logic       OP_ENCRYPT = 1'b0;
  localparam logic       OP_DECRYPT = 1'b1;
  localparam logic [2:0] REG_KEY0 = 3'd0;
  localparam logic [2:0] REG_KEY1 = 3'd1;
  localparam logic [2:0] REG_KEY2 = 3'd2;
  localparam logic [2:0] REG_KEY3 = 3'd3;
  localparam logic [2:0] REG_SPARE = 3'd5;
  localparam int         PHASE_BLOCKS = 100;

  typedef struct packed {
    logic        kind;
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_beat_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_pair_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_kind;
  logic [63:0] in_block_high;
  logic [63:0] in_block_low;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  aes256_block_cipher uut (.*);

  cipher_beat_t pending_blocks[$];
  block_pair_t  expected_blocks[$];
  logic [63:0]  key_regs[4];
  logic [31:0]  sched[60];
  int sender_idle_pct;
  int receiver_idle_pct;
  int stall_cycles;
  int error_count;
  int accepted_count;
  int result_count;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  // Rebuilt after every key load rather than tracked; cheap enough and avoids a stale flag.
  task automatic build_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 8; i++) sched[i] = i[0] ? key_regs[i/2][31:0] : key_regs[i/2][63:32];
    for (int i = 8; i < 60; i++) begin
      t = sched[i-1];
      if (i % 8 == 0) begin
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (i % 8 == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i-8] ^ t;
    end
  endtask

  // State byte s[c*4+r] is column c, row r; byte 0 is the block's MSB.
  function automatic block_pair_t cipher_block(input cipher_beat_t b);
    logic [7:0] s[16];
    logic [7:0] t[16];
    logic [7:0] a[4];
    logic [7:0] m[4];
    block_pair_t res;
    for (int i = 0; i < 8; i++) begin
      s[i]   = b.hi[63-8*i -: 8];
      s[8+i] = b.lo[63-8*i -: 8];
    end
    m = (b.kind == OP_DECRYPT) ? '{8'd14, 8'd11, 8'd13, 8'd9} : '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int step = 0; step <= 14; step++) begin
      int rnd;
      rnd = (b.kind == OP_DECRYPT) ? 14 - step : step;
      if (step > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            if (b.kind == OP_DECRYPT) t[((c+r)&3)*4+r] = INV_SBOX[s[c*4+r]];
            else t[c*4+r] = FWD_SBOX[s[((c+r)&3)*4+r]];
        s = t;
        if (b.kind == OP_ENCRYPT && step < 14) begin
          for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) a[k] = s[c*4+k];
            for (int r = 0; r < 4; r++) begin
              s[c*4+r] = 8'h00;
              for (int k = 0; k < 4; k++) s[c*4+r] ^= gf_mul(a[k], m[(k-r+4)&3]);
            end
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) s[c*4+r] ^= sched[rnd*4+c][31-8*r -: 8];
      if (b.kind == OP_DECRYPT && step > 0 && step < 14) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) a[k] = s[c*4+k];
          for (int r = 0; r < 4; r++) begin
            s[c*4+r] = 8'h00;
            for (int k = 0; k < 4; k++) s[c*4+r] ^= gf_mul(a[k], m[(k-r+4)&3]);
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63-8*i -: 8] = s[i];
      res.lo[63-8*i -: 8] = s[8+i];
    end
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  // Driver: one beat held until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        expected_blocks.push_back(cipher_block({in_kind, in_block_high, in_block_low}));
        accepted_count <= accepted_count + 1;
      end
      if (pending_blocks.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        cipher_beat_t b;
        b = pending_blocks.pop_front();
        in_valid <= 1'b1;
        in_kind <= b.kind;
        in_block_high <= b.hi;
        in_block_low <= b.lo;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor, with the receiver's random and long stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        block_pair_t exp_blk;
        result_count <= result_count + 1;
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result beat hi=%h lo=%h", $time,
                   out_result_high, out_result_low);
          error_count <= error_count + 1;
        end else begin
          exp_blk = expected_blocks.pop_front();
          if (exp_blk.hi !== out_result_high) begin
            $display("%0t: result_high expected %h actual %h", $time, exp_blk.hi,
                     out_result_high);
            error_count <= error_count + 1;
          end
          if (exp_blk.lo !== out_result_low) begin
            $display("%0t: result_low expected %h actual %h", $time, exp_blk.lo,
                     out_result_low);
            error_count <= error_count + 1;
          end
        end
      end
      if (stall_cycles > 0) begin
        stall_cycles <= stall_cycles - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  task automatic write_key(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx <= REG_KEY3) key_regs[idx[1:0]] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_blocks.size() == 0 && !in_valid && expected_blocks.size() == 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_key(input int mode);
    for (int i = 0; i < 4; i++) begin
      case (mode)
        0: write_key(REG_KEY0 + 3'(i), '0);
        1: write_key(REG_KEY0 + 3'(i), '1);
        default: write_key(REG_KEY0 + 3'(i), {$urandom(), $urandom()});
      endcase
    end
    build_schedule();
  endtask

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++)
      pending_blocks.push_back({1'($urandom_range(0, 1)), rand64(), rand64()});
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = OP_ENCRYPT;
    in_block_high = '0;
    in_block_low = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_KEY0;
    cfg_wdata = '0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    stall_cycles = 0;
    error_count = 0;
    accepted_count = 0;
    result_count = 0;
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    build_schedule();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Blocks under the reset key, before any register write.
    pending_blocks.push_back({OP_ENCRYPT, 64'h0, 64'h0});
    pending_blocks.push_back({OP_DECRYPT, 64'h0, 64'h0});
    drain();

    // Published FIPS-197 AES-256 example key and plaintext.
    write_key(REG_KEY0, 64'h0001020304050607);
    write_key(REG_KEY1, 64'h08090a0b0c0d0e0f);
    write_key(REG_KEY2, 64'h1011121314151617);
    write_key(REG_KEY3, 64'h18191a1b1c1d1e1f);
    write_key(REG_SPARE, 64'hdeadbeefdeadbeef);  // index past the key words is ignored
    build_schedule();
    pending_blocks.push_back({OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff});
    pending_blocks.push_back({OP_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089});
    pending_blocks.push_back({OP_ENCRYPT, 64'hffffffffffffffff, 64'hffffffffffffffff});
    pending_blocks.push_back({OP_DECRYPT, 64'hffffffffffffffff, 64'hffffffffffffffff});
    pending_blocks.push_back({OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001});
    pending_blocks.push_back({OP_DECRYPT, 64'h0000000000000001, 64'h8000000000000000});
    drain();

    load_key(1);
    pending_blocks.push_back({OP_ENCRYPT, 64'h0, 64'hffffffffffffffff});
    pending_blocks.push_back({OP_DECRYPT, 64'hffffffffffffffff, 64'h0});
    drain();
    load_key(0);
    pending_blocks.push_back({OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210});
    drain();

    // A single key word change must also trigger re-expansion.
    write_key(REG_KEY2, 64'h0f0e0d0c0b0a0908);
    build_schedule();
    pending_blocks.push_back({OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa});
    drain();

    // Long receiver hold-off while the sender keeps offering beats.
    stall_cycles = 300;
    queue_random(20);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase % 3)
        0: begin sender_idle_pct = 6;  receiver_idle_pct = 88; end
        1: begin sender_idle_pct = 88; receiver_idle_pct = 6;  end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      load_key(phase == 4 ? 1 : 2);
      queue_random(PHASE_BLOCKS);
      drain();
    end

    $display("Covered %0d blocks in both directions under %0d key settings,",
             accepted_count, 14);
    $display("with random idling on both sides and a long output stall.");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
